// ===== rtl/wblsu_pkg.sv =====
// ----------------------------------------------------------------------------
// wblsu_pkg
// Shared types and constants of the write buffer load-store unit: command and
// access width codes, buffer geometry, and the word structs of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

package wblsu_pkg;

    // Buffer geometry
    localparam int DEPTH = 4;                     // entries, 2 to 16
    localparam int IW    = $clog2(DEPTH);         // entry index
    localparam int CW    = $clog2(DEPTH + 1);     // index that can hold DEPTH

    // Command codes (6 and 7 act as idle)
    localparam logic [2:0] CMD_IDLE       = 3'd0;
    localparam logic [2:0] CMD_READ       = 3'd1;
    localparam logic [2:0] CMD_WRITE      = 3'd2;
    localparam logic [2:0] CMD_FLUSH      = 3'd3;
    localparam logic [2:0] CMD_WRITEBACK  = 3'd4;
    localparam logic [2:0] CMD_INVALIDATE = 3'd5;

    // Access width codes (code 3 acts as a word)
    localparam logic [1:0] WID_WORD = 2'd0;
    localparam logic [1:0] WID_BYTE = 2'd1;
    localparam logic [1:0] WID_HALF = 2'd2;

    // Input word
    typedef struct packed {
        logic [2:0]  command;
        logic [1:0]  access_width;
        logic        sign_extend;
        logic [31:0] address;
        logic [31:0] write_data;
        logic [31:0] mem_read_data;
        logic        mem_read_ack;
        logic        mem_write_ack;
        logic        special_address;
    } t_in_item;

    // Result word
    typedef struct packed {
        logic        done_res;
        logic        misaligned;
        logic [31:0] read_data;
        logic        mem_read_req;
        logic [3:0]  mem_read_bytes;
        logic        mem_write_req;
        logic [29:0] mem_write_word_addr;
        logic [31:0] mem_write_data;
        logic [3:0]  mem_write_bytes;
        logic        mem_writeback_req;
        logic        mem_invalidate_req;
    } t_out_item;

    // Decoded access, decoder to buffer
    typedef struct packed {
        logic        misal;
        logic        is_rd;
        logic        is_wr;
        logic        is_fl;
        logic        is_cache;
        logic        is_wb;
        logic [3:0]  bsel;
        logic [31:0] wbdata;
    } t_access;

    // Buffer status, buffer to top level
    typedef struct packed {
        logic        done;
        logic        rreq;
        logic        wreq;
        logic        wbreq;
        logic        invreq;
        logic [31:0] merged;
        logic [29:0] head_addr;
        logic [31:0] head_data;
        logic [3:0]  head_bytes;
    } t_buf_status;

endpackage

`default_nettype wire

// ===== rtl/wblsu_decode.sv =====
// ----------------------------------------------------------------------------
// wblsu_decode
// Access decoder: alignment check, command qualification, byte selects and
// store data replicated across the word lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module wblsu_decode (
    input  wire logic [2:0]      i_command,
    input  wire logic [1:0]      i_access_width,
    input  wire logic [31:0]     i_address,
    input  wire logic [31:0]     i_write_data,
    output wblsu_pkg::t_access   o_access
);

    logic       misal;
    logic [3:0] bsel;

    always_comb begin
        o_access = '0;

        // alignment: halfword needs bit 0 clear, word (and code 3) both bits
        case (i_access_width)
            wblsu_pkg::WID_HALF: misal = i_address[0];
            wblsu_pkg::WID_BYTE: misal = 1'b0;
            default:             misal = (i_address[1:0] != 2'b00);
        endcase

        // byte selects and lane-replicated store data
        case (i_access_width)
            wblsu_pkg::WID_BYTE: begin
                bsel = 4'b0001 << i_address[1:0];
                o_access.wbdata = {4{i_write_data[7:0]}};
            end
            wblsu_pkg::WID_HALF: begin
                bsel = 4'b0011 << i_address[1:0];
                o_access.wbdata = {2{i_write_data[15:0]}};
            end
            default: begin
                bsel = 4'b1111;
                o_access.wbdata = i_write_data;
            end
        endcase

        o_access.misal    = misal;
        o_access.is_rd    = !misal && (i_command == wblsu_pkg::CMD_READ);
        o_access.is_wr    = !misal && (i_command == wblsu_pkg::CMD_WRITE);
        o_access.is_fl    = !misal && (i_command == wblsu_pkg::CMD_FLUSH);
        o_access.is_wb    = !misal && (i_command == wblsu_pkg::CMD_WRITEBACK);
        o_access.is_cache = !misal && (i_command == wblsu_pkg::CMD_WRITEBACK ||
                                       i_command == wblsu_pkg::CMD_INVALIDATE);
        o_access.bsel     = (o_access.is_cache || misal) ? 4'b0000 : bsel;
    end

endmodule

`default_nettype wire

// ===== rtl/wblsu_load_fmt.sv =====
// ----------------------------------------------------------------------------
// wblsu_load_fmt
// Load formatter: picks the addressed byte or halfword out of the merged
// word and zero- or sign-extends it.
// ----------------------------------------------------------------------------
`default_nettype none

module wblsu_load_fmt (
    input  wire logic [31:0] i_word,
    input  wire logic [1:0]  i_access_width,
    input  wire logic        i_sign_extend,
    input  wire logic [1:0]  i_byte_offset,
    input  wire logic        i_misal,
    output logic      [31:0] o_read_data
);

    logic [31:0] shifted;
    logic [7:0]  byte_val;
    logic [15:0] half_val;

    always_comb begin
        // byte 0 is the most significant lane
        shifted  = i_word >> {~i_byte_offset, 3'b000};
        byte_val = shifted[7:0];
        half_val = i_byte_offset[1] ? i_word[15:0] : i_word[31:16];

        case (i_access_width)
            wblsu_pkg::WID_BYTE:
                o_read_data = {{24{i_sign_extend & byte_val[7]}}, byte_val};
            wblsu_pkg::WID_HALF:
                o_read_data = {{16{i_sign_extend & half_val[15]}}, half_val};
            default:
                o_read_data = i_word;
        endcase

        if (i_misal) o_read_data = '0;
    end

endmodule

`default_nettype wire

// ===== rtl/wblsu_buffer.sv =====
// ----------------------------------------------------------------------------
// wblsu_buffer
// In-order coalescing write buffer: hit and free-slot search, load
// forwarding, store merge, head drain with shift, and cache op gating.
// ----------------------------------------------------------------------------
`default_nettype none

module wblsu_buffer (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire wblsu_pkg::t_access     i_access,
    input  wire logic [29:0]            i_word_addr,
    input  wire logic [31:0]            i_mem_read_data,
    input  wire logic                   i_mem_read_ack,
    input  wire logic                   i_mem_write_ack,
    input  wire logic                   i_special,
    output wblsu_pkg::t_buf_status      o_status
);

    localparam int DEPTH = wblsu_pkg::DEPTH;
    localparam int IW    = wblsu_pkg::IW;
    localparam int CW    = wblsu_pkg::CW;

    // buffer storage
    logic [29:0] r_addr  [DEPTH];
    logic [31:0] r_data  [DEPTH];
    logic [3:0]  r_valid [DEPTH];
    logic        r_hwp;

    logic [29:0] n_addr  [DEPTH];
    logic [31:0] n_data  [DEPTH];
    logic [3:0]  n_valid [DEPTH];
    logic        n_hwp;

    logic          hit_ok, free_ok, empty;
    logic [IW-1:0] hit_idx, free_idx;
    logic [3:0]    hit_valid;
    logic [31:0]   hit_data;
    logic          e_ok, e_in, e_is0;
    logic [CW-1:0] e_idx, w_idx;
    logic [31:0]   old_data, new_data;
    logic [3:0]    old_valid;
    logic          dont0, remove, wr;

    always_comb begin
        // lowest-index hit and lowest free slot
        hit_ok   = 1'b0;
        hit_idx  = '0;
        free_ok  = 1'b0;
        free_idx = '0;
        empty    = 1'b1;
        for (int n = DEPTH - 1; n >= 0; n--) begin
            if (r_valid[n] != 4'b0000 && r_addr[n] == i_word_addr) begin
                hit_ok  = 1'b1;
                hit_idx = IW'(n);
            end
            if (r_valid[n] == 4'b0000) begin
                free_ok  = 1'b1;
                free_idx = IW'(n);
            end else begin
                empty = 1'b0;
            end
        end
        hit_valid = hit_ok ? r_valid[hit_idx] : 4'b0000;
        hit_data  = r_data[hit_idx];

        // forward valid buffered bytes over the memory word
        o_status.merged = i_mem_read_data;
        for (int b = 0; b < 4; b++)
            if (hit_valid[b]) o_status.merged[31 - 8*b -: 8] = hit_data[31 - 8*b -: 8];

        // handshake toward the execution unit and memory
        o_status.done   = 1'b0;
        o_status.rreq   = 1'b0;
        o_status.wbreq  = 1'b0;
        o_status.invreq = 1'b0;
        o_status.wreq   = r_hwp;
        if (i_access.is_rd) begin
            if (hit_ok && (i_access.bsel & ~hit_valid) == 4'b0000) begin
                o_status.done = 1'b1;
            end else begin
                o_status.rreq = 1'b1;
                o_status.done = i_mem_read_ack;
            end
        end
        if (i_access.is_fl && empty) o_status.done = 1'b1;
        if (empty && i_access.is_cache) begin
            o_status.wreq   = 1'b0;
            o_status.wbreq  = i_access.is_wb;
            o_status.invreq = !i_access.is_wb;
            o_status.done   = i_mem_write_ack;
        end

        o_status.head_addr  = r_addr[0];
        o_status.head_data  = r_data[0];
        o_status.head_bytes = r_valid[0];

        // target entry of a store or cache op; DEPTH means full
        e_ok  = 1'b0;
        e_idx = '0;
        if (i_access.is_wr) begin
            e_ok = 1'b1;
            if (hit_ok && !i_special) e_idx = CW'(hit_idx);
            else if (free_ok)         e_idx = CW'(free_idx);
            else                      e_idx = CW'(DEPTH);
        end
        if (i_access.is_cache) begin
            e_ok  = empty;
            e_idx = '0;
        end
        e_is0 = e_ok && (e_idx == '0);
        e_in  = e_ok && (e_idx < CW'(DEPTH));
        old_data  = e_in ? r_data[e_idx[IW-1:0]]  : 32'd0;
        old_valid = e_in ? r_valid[e_idx[IW-1:0]] : 4'b0000;

        // head drain and write decision
        dont0  = r_hwp && ((i_access.is_rd && hit_ok && hit_idx == '0) ||
                           (i_access.is_wr && e_is0));
        remove = !dont0 && (!r_hwp || i_mem_write_ack) && !e_is0;
        w_idx  = remove ? e_idx - CW'(1) : e_idx;
        wr     = e_ok && (remove || e_idx < CW'(DEPTH)) &&
                 !(i_special && w_idx != '0) && !dont0;
        if (wr) o_status.done = 1'b1;

        new_data = old_data;
        for (int b = 0; b < 4; b++)
            if (i_access.bsel[b]) new_data[31 - 8*b -: 8] = i_access.wbdata[31 - 8*b -: 8];

        // next state: shift on drain, then the store
        n_hwp = r_hwp;
        if (i_mem_write_ack) n_hwp = 1'b0;
        for (int n = 0; n < DEPTH; n++) begin
            n_addr[n]  = r_addr[n];
            n_data[n]  = r_data[n];
            n_valid[n] = r_valid[n];
        end
        if (remove) begin
            n_hwp = (r_valid[1] != 4'b0000);
            for (int n = 0; n < DEPTH - 1; n++) begin
                n_addr[n]  = r_addr[n + 1];
                n_data[n]  = r_data[n + 1];
                n_valid[n] = r_valid[n + 1];
            end
            n_valid[DEPTH - 1] = 4'b0000;
        end
        if (wr) begin
            n_addr[w_idx[IW-1:0]]  = i_word_addr;
            n_data[w_idx[IW-1:0]]  = new_data;
            n_valid[w_idx[IW-1:0]] = old_valid | i_access.bsel;
            if (w_idx == '0) n_hwp = 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hwp <= 1'b0;
            for (int n = 0; n < DEPTH; n++) r_valid[n] <= 4'b0000;
        end else if (i_en) begin
            r_hwp <= n_hwp;
            for (int n = 0; n < DEPTH; n++) r_valid[n] <= n_valid[n];
        end
    end

    // entry payload, undefined until written
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int n = 0; n < DEPTH; n++) begin
                r_addr[n] <= n_addr[n];
                r_data[n] <= n_data[n];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/write_buffer_load_store_unit.sv =====
// ----------------------------------------------------------------------------
// write_buffer_load_store_unit
// A word accepted into the input register is processed by the buffer logic and
// its result is captured in the result register. One word per cycle while the
// output is not stalled, set by the single-pass buffer logic between the two.
// Reset (synchronous, active low) empties the buffer and clears the pending
// head write; entry addresses and data are left as they are.
// ----------------------------------------------------------------------------
`default_nettype none

module write_buffer_load_store_unit (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire wblsu_pkg::t_in_item  i_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output wblsu_pkg::t_out_item      o_out
);

    logic                   r_in_valid;
    wblsu_pkg::t_in_item    r_in;
    logic                   r_out_valid;
    wblsu_pkg::t_out_item   r_out;

    logic                   advance;
    logic                   accept_in;
    wblsu_pkg::t_access     access;
    wblsu_pkg::t_buf_status status;
    logic [31:0]            read_data;
    wblsu_pkg::t_out_item   n_out;

    // pipeline flow
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign accept_in  = i_in_valid && !o_in_stall;

    wblsu_decode u_decode (
        .i_command      (r_in.command),
        .i_access_width (r_in.access_width),
        .i_address      (r_in.address),
        .i_write_data   (r_in.write_data),
        .o_access       (access)
    );

    wblsu_buffer u_buffer (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (advance),
        .i_access        (access),
        .i_word_addr     (r_in.address[31:2]),
        .i_mem_read_data (r_in.mem_read_data),
        .i_mem_read_ack  (r_in.mem_read_ack),
        .i_mem_write_ack (r_in.mem_write_ack),
        .i_special       (r_in.special_address),
        .o_status        (status)
    );

    wblsu_load_fmt u_load_fmt (
        .i_word         (status.merged),
        .i_access_width (r_in.access_width),
        .i_sign_extend  (r_in.sign_extend),
        .i_byte_offset  (r_in.address[1:0]),
        .i_misal        (access.misal),
        .o_read_data    (read_data)
    );

    // result word
    always_comb begin
        n_out.done_res            = status.done;
        n_out.misaligned          = access.misal;
        n_out.read_data           = read_data;
        n_out.mem_read_req        = status.rreq;
        n_out.mem_read_bytes      = access.bsel;
        n_out.mem_write_req       = status.wreq;
        n_out.mem_write_word_addr = status.head_addr;
        n_out.mem_write_data      = status.head_data;
        n_out.mem_write_bytes     = status.head_bytes;
        n_out.mem_writeback_req   = status.wbreq;
        n_out.mem_invalidate_req  = status.invreq;
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept_in)    r_in_valid <= 1'b1;
            else if (advance) r_in_valid <= 1'b0;
            if (advance)           r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept_in) r_in  <= i_in;
        if (advance)   r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire
